// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the scalar unary ALU modules. They turn
// into nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge except while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_RAW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst, prop, msg)
`define ASSERT_RAW(lbl, clk, prop, msg)
`endif
`endif

// ===== design/sua_pkg.sv =====
// ---------------------------------------------------------------------------
// Scalar unary ALU package
// Opcodes, result kinds, stage payload types and small byte helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package sua_pkg;

  // Operation codes.
  localparam logic [5:0] OP_SETPC_B64      = 6'd0;
  localparam logic [5:0] OP_GETPC_B64      = 6'd1;
  localparam logic [5:0] OP_ABS_I32        = 6'd2;
  localparam logic [5:0] OP_AND_SAVEEXEC   = 6'd3;
  localparam logic [5:0] OP_ANDN1_SAVEEXEC = 6'd4;
  localparam logic [5:0] OP_ANDN1_WREXEC   = 6'd5;
  localparam logic [5:0] OP_ANDN2_SAVEEXEC = 6'd6;
  localparam logic [5:0] OP_ANDN2_WREXEC   = 6'd7;
  localparam logic [5:0] OP_BCNT0_B32      = 6'd8;
  localparam logic [5:0] OP_BCNT0_B64      = 6'd9;
  localparam logic [5:0] OP_BCNT1_B32      = 6'd10;
  localparam logic [5:0] OP_BCNT1_B64      = 6'd11;
  localparam logic [5:0] OP_BITREPLICATE   = 6'd12;
  localparam logic [5:0] OP_BITSET0_B32    = 6'd13;
  localparam logic [5:0] OP_BITSET0_B64    = 6'd14;
  localparam logic [5:0] OP_BITSET1_B32    = 6'd15;
  localparam logic [5:0] OP_BITSET1_B64    = 6'd16;
  localparam logic [5:0] OP_BREV_B32       = 6'd17;
  localparam logic [5:0] OP_BREV_B64       = 6'd18;
  localparam logic [5:0] OP_CMOV_B32       = 6'd19;
  localparam logic [5:0] OP_CMOV_B64       = 6'd20;
  localparam logic [5:0] OP_FF0_B32        = 6'd21;
  localparam logic [5:0] OP_FF0_B64        = 6'd22;
  localparam logic [5:0] OP_FF1_B32        = 6'd23;
  localparam logic [5:0] OP_FF1_B64        = 6'd24;
  localparam logic [5:0] OP_FLBIT_B32      = 6'd25;
  localparam logic [5:0] OP_FLBIT_B64      = 6'd26;
  localparam logic [5:0] OP_FLBIT_I32      = 6'd27;
  localparam logic [5:0] OP_FLBIT_I64      = 6'd28;
  localparam logic [5:0] OP_MOV_B32        = 6'd29;
  localparam logic [5:0] OP_MOV_B64        = 6'd30;
  localparam logic [5:0] OP_NAND_SAVEEXEC  = 6'd31;
  localparam logic [5:0] OP_NOR_SAVEEXEC   = 6'd32;
  localparam logic [5:0] OP_NOT_B32        = 6'd33;
  localparam logic [5:0] OP_NOT_B64        = 6'd34;
  localparam logic [5:0] OP_OR_SAVEEXEC    = 6'd35;
  localparam logic [5:0] OP_ORN2_SAVEEXEC  = 6'd36;
  localparam logic [5:0] OP_QUADMASK_B32   = 6'd37;
  localparam logic [5:0] OP_QUADMASK_B64   = 6'd38;
  localparam logic [5:0] OP_SEXT_I8        = 6'd39;
  localparam logic [5:0] OP_SEXT_I16       = 6'd40;
  localparam logic [5:0] OP_SWAPPC_B64     = 6'd41;
  localparam logic [5:0] OP_WQM_B32        = 6'd42;
  localparam logic [5:0] OP_WQM_B64        = 6'd43;
  localparam logic [5:0] OP_XNOR_SAVEEXEC  = 6'd44;
  localparam logic [5:0] OP_XOR_SAVEEXEC   = 6'd45;

  // Where the final destination comes from.
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_POPCNT = 2'd1;
  localparam logic [1:0] KIND_LOWEST = 2'd2;
  localparam logic [1:0] KIND_LEAD   = 2'd3;

  localparam logic [63:0] NOT_FOUND = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] PC_STEP   = 64'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic       scc_dst;     // SCC becomes dst != 0
    logic       scc_exec;    // SCC becomes new EXEC != 0
    logic       scc;         // SCC when neither applies
    logic       pc_changed;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] dst;
    logic [63:0] exec_v;
    logic [63:0] pc;
    logic [63:0] opnd;       // operand of the count and search unit
  } s1_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [63:0]      dst;
    logic [63:0]      exec_v;
    logic [63:0]      pc;
    logic [7:0][3:0]  cnt;
    logic [7:0]       any;
    logic [7:0][2:0]  lo;
    logic [7:0][2:0]  hi;
  } s2_t;

  typedef struct packed {
    logic [63:0] dst;
    logic [63:0] exec_v;
    logic        scc;
    logic        pc_changed;
    logic [63:0] pc;
  } out_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + {3'b000, b[i]};
    return n;
  endfunction

  function automatic logic [2:0] lo_idx8(input logic [7:0] b);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) if (b[i]) idx = 3'(i);
    return idx;
  endfunction

  function automatic logic [2:0] hi_idx8(input logic [7:0] b);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) if (b[i]) idx = 3'(i);
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== design/scalar_unary_alu.sv =====
// ---------------------------------------------------------------------------
// Scalar unary ALU
// Three-stage pipelined executor for single-source scalar instructions.
// ---------------------------------------------------------------------------
// Each input beat carries one instruction: the opcode, the source, the old
// destination, EXEC, SCC and PC. Each beat produces exactly one result beat
// with the new destination, EXEC, SCC, a PC-redirect flag and the PC, in the
// order the instructions came in. The block takes one beat every cycle while
// the output is not stalled. Each beat passes through three register
// stages before its result is presented: decode with the plain bit
// operations and the PC adder, then a byte stage that counts ones and
// finds the lowest and highest set bit of each operand byte, then a result
// stage that merges the eight bytes and forms SCC. Up to three instructions
// are in flight. When the output is stalled, each stage holds its beat and
// keeps accepting only while there is room ahead of it, so nothing is
// dropped or repeated. Searches that find no bit return 0x00000000_FFFFFFFF,
// and every 32-bit form returns its result zero-extended to 64 bits, except
// that CMOV_B32 with SCC clear keeps the old destination. Unused opcodes
// pass the state through unchanged. The block keeps no state beyond the pipeline.
`default_nettype none
`include "assert_macros.svh"

module scalar_unary_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  action,
  input  wire logic [63:0] src,
  input  wire logic [63:0] dst_old,
  input  wire logic [63:0] exec_in,
  input  wire logic        scc_in,
  input  wire logic [63:0] pc_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      dst_new,
  output logic [63:0]      exec_out,
  output logic             scc_out,
  output logic             pc_changed,
  output logic [63:0]      pc_out
);

  // Stage handshakes: each stage is ready when empty or when its beat leaves.
  logic          s1_valid;
  logic          s1_ready;
  sua_pkg::s1_t  s1;
  logic          s2_valid;
  logic          s2_ready;
  sua_pkg::s2_t  s2;
  sua_pkg::out_t res;

  sua_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .action  (action),
    .src     (src),
    .dst_old (dst_old),
    .exec_in (exec_in),
    .scc_in  (scc_in),
    .pc_in   (pc_in),
    .m_valid (s1_valid),
    .m_ready (s1_ready),
    .q       (s1)
  );

  sua_count u_count (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s1_valid),
    .s_ready (s1_ready),
    .d       (s1),
    .m_valid (s2_valid),
    .m_ready (s2_ready),
    .q       (s2)
  );

  sua_final u_final (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s2_valid),
    .s_ready (s2_ready),
    .d       (s2),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .q       (res)
  );

  // The result register drives the output beat directly.
  assign dst_new    = res.dst;
  assign exec_out   = res.exec_v;
  assign scc_out    = res.scc;
  assign pc_changed = res.pc_changed;
  assign pc_out     = res.pc;

  `ASSERT_RAW(a_top_rst_empty, clk, rst |=> !out_valid && !s1_valid && !s2_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== design/sua_prep.sv =====
// ---------------------------------------------------------------------------
// Scalar unary ALU decode stage
// Decodes the opcode, forms all plain bit results, EXEC and PC, picks the SCC
// source and prepares the operand for the count and search unit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sua_prep (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_valid,
  output logic               s_ready,
  input  wire logic [5:0]    action,
  input  wire logic [63:0]   src,
  input  wire logic [63:0]   dst_old,
  input  wire logic [63:0]   exec_in,
  input  wire logic          scc_in,
  input  wire logic [63:0]   pc_in,
  output logic               m_valid,
  input  wire logic          m_ready,
  output sua_pkg::s1_t       q
);

  sua_pkg::s1_t d;
  logic [31:0]  s32;
  logic [31:0]  s32_neg;
  logic [63:0]  pc_plus;
  logic [63:0]  rep;
  logic [63:0]  rev64;
  logic [31:0]  rev32;
  logic [15:0]  qmask;
  logic [63:0]  wqm;

  assign s32     = src[31:0];
  assign s32_neg = 32'd0 - s32;
  assign pc_plus = pc_in + sua_pkg::PC_STEP;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rep[2*i +: 2] = {2{s32[i]}};
      rev32[i]      = s32[31-i];
    end
    for (int i = 0; i < 64; i++) rev64[i] = src[63-i];
    for (int i = 0; i < 16; i++) begin
      qmask[i]      = |src[4*i +: 4];
      wqm[4*i +: 4] = {4{qmask[i]}};
    end
  end

  always_comb begin
    d                = '0;
    d.ctl.kind       = sua_pkg::KIND_SIMPLE;
    d.ctl.scc        = scc_in;
    d.dst            = dst_old;
    d.exec_v         = exec_in;
    d.pc             = pc_in;
    unique case (action)
      sua_pkg::OP_SETPC_B64: begin
        d.ctl.pc_changed = 1'b1;
        d.pc             = src;
      end
      sua_pkg::OP_GETPC_B64: d.dst = pc_plus;
      sua_pkg::OP_ABS_I32: begin
        d.dst         = {32'd0, s32[31] ? s32_neg : s32};
        d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_AND_SAVEEXEC: begin
        d.exec_v = src & exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_ANDN1_SAVEEXEC: begin
        d.exec_v = ~src & exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_ANDN1_WREXEC: begin
        d.exec_v = ~src & exec_in; d.dst = ~src & exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_ANDN2_SAVEEXEC: begin
        d.exec_v = src & ~exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_ANDN2_WREXEC: begin
        d.exec_v = src & ~exec_in; d.dst = src & ~exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_BCNT0_B32: begin
        d.ctl.kind = sua_pkg::KIND_POPCNT; d.opnd = {32'd0, ~s32}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_BCNT0_B64: begin
        d.ctl.kind = sua_pkg::KIND_POPCNT; d.opnd = ~src; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_BCNT1_B32: begin
        d.ctl.kind = sua_pkg::KIND_POPCNT; d.opnd = {32'd0, s32}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_BCNT1_B64: begin
        d.ctl.kind = sua_pkg::KIND_POPCNT; d.opnd = src; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_BITREPLICATE: d.dst = rep;
      sua_pkg::OP_BITSET0_B32:
        d.dst = {32'd0, dst_old[31:0] & ~(32'd1 << src[4:0])};
      sua_pkg::OP_BITSET0_B64: d.dst = dst_old & ~(64'd1 << src[5:0]);
      sua_pkg::OP_BITSET1_B32:
        d.dst = {32'd0, dst_old[31:0] | (32'd1 << src[4:0])};
      sua_pkg::OP_BITSET1_B64: d.dst = dst_old | (64'd1 << src[5:0]);
      sua_pkg::OP_BREV_B32: d.dst = {32'd0, rev32};
      sua_pkg::OP_BREV_B64: d.dst = rev64;
      sua_pkg::OP_CMOV_B32: if (scc_in) d.dst = {32'd0, s32};
      sua_pkg::OP_CMOV_B64: if (scc_in) d.dst = src;
      sua_pkg::OP_FF0_B32: begin
        d.ctl.kind = sua_pkg::KIND_LOWEST; d.opnd = {32'd0, ~s32};
      end
      sua_pkg::OP_FF0_B64: begin
        d.ctl.kind = sua_pkg::KIND_LOWEST; d.opnd = ~src;
      end
      sua_pkg::OP_FF1_B32: begin
        d.ctl.kind = sua_pkg::KIND_LOWEST; d.opnd = {32'd0, s32};
      end
      sua_pkg::OP_FF1_B64: begin
        d.ctl.kind = sua_pkg::KIND_LOWEST; d.opnd = src;
      end
      // The 32-bit leading searches sit in the upper half, so that the
      // distance from bit 63 equals the distance from bit 31.
      sua_pkg::OP_FLBIT_B32: begin
        d.ctl.kind = sua_pkg::KIND_LEAD; d.opnd = {s32, 32'd0};
      end
      sua_pkg::OP_FLBIT_B64: begin
        d.ctl.kind = sua_pkg::KIND_LEAD; d.opnd = src;
      end
      sua_pkg::OP_FLBIT_I32: begin
        d.ctl.kind = sua_pkg::KIND_LEAD;
        d.opnd     = {s32[31] ? ~s32 : s32, 32'd0};
      end
      sua_pkg::OP_FLBIT_I64: begin
        d.ctl.kind = sua_pkg::KIND_LEAD;
        d.opnd     = src[63] ? ~src : src;
      end
      sua_pkg::OP_MOV_B32: d.dst = {32'd0, s32};
      sua_pkg::OP_MOV_B64: d.dst = src;
      sua_pkg::OP_NAND_SAVEEXEC: begin
        d.exec_v = ~(src & exec_in); d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_NOR_SAVEEXEC: begin
        d.exec_v = ~(src | exec_in); d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_NOT_B32: begin
        d.dst = {32'd0, ~s32}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_NOT_B64: begin
        d.dst = ~src; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_OR_SAVEEXEC: begin
        d.exec_v = src | exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_ORN2_SAVEEXEC: begin
        d.exec_v = src | ~exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_QUADMASK_B32: begin
        d.dst = {56'd0, qmask[7:0]}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_QUADMASK_B64: begin
        d.dst = {48'd0, qmask}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_SEXT_I8:  d.dst = {32'd0, {24{src[7]}}, src[7:0]};
      sua_pkg::OP_SEXT_I16: d.dst = {32'd0, {16{src[15]}}, src[15:0]};
      sua_pkg::OP_SWAPPC_B64: begin
        d.dst            = pc_plus;
        d.ctl.pc_changed = 1'b1;
        d.pc             = src;
      end
      sua_pkg::OP_WQM_B32: begin
        d.dst = {32'd0, wqm[31:0]}; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_WQM_B64: begin
        d.dst = wqm; d.ctl.scc_dst = 1'b1;
      end
      sua_pkg::OP_XNOR_SAVEEXEC: begin
        d.exec_v = ~(src ^ exec_in); d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      sua_pkg::OP_XOR_SAVEEXEC: begin
        d.exec_v = src ^ exec_in; d.dst = exec_in; d.ctl.scc_exec = 1'b1;
      end
      default: ;
    endcase
  end

  assign s_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s_ready) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q <= d;
    end
  end

  `ASSERT_CLKD(a_prep_hold, clk, rst, m_valid && !m_ready |=> m_valid && $stable(q), "decode stage lost a stalled beat")
  `ASSERT_CLKD(a_prep_pc_kind, clk, rst, m_valid && q.ctl.pc_changed |-> q.ctl.kind == sua_pkg::KIND_SIMPLE, "PC redirect decoded with a unit result")
  `ASSERT_CLKD(a_prep_scc_src, clk, rst, m_valid |-> !(q.ctl.scc_dst && q.ctl.scc_exec), "two SCC sources decoded at once")

endmodule

`default_nettype wire

// ===== design/sua_count.sv =====
// ---------------------------------------------------------------------------
// Scalar unary ALU byte stage
// Counts ones and finds the lowest and highest set bit in each operand byte.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sua_count (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_valid,
  output logic               s_ready,
  input  wire sua_pkg::s1_t  d,
  output logic               m_valid,
  input  wire logic          m_ready,
  output sua_pkg::s2_t       q
);

  sua_pkg::s2_t n;

  always_comb begin
    n.ctl    = d.ctl;
    n.dst    = d.dst;
    n.exec_v = d.exec_v;
    n.pc     = d.pc;
    for (int i = 0; i < 8; i++) begin
      n.cnt[i] = sua_pkg::popcnt8(d.opnd[8*i +: 8]);
      n.any[i] = |d.opnd[8*i +: 8];
      n.lo[i]  = sua_pkg::lo_idx8(d.opnd[8*i +: 8]);
      n.hi[i]  = sua_pkg::hi_idx8(d.opnd[8*i +: 8]);
    end
  end

  assign s_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s_ready) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q <= n;
    end
  end

  `ASSERT_CLKD(a_cnt_hold, clk, rst, m_valid && !m_ready |=> m_valid && $stable(q), "byte stage lost a stalled beat")

endmodule

`default_nettype wire

// ===== design/sua_final.sv =====
// ---------------------------------------------------------------------------
// Scalar unary ALU result stage
// Merges the byte counts and searches, picks the destination, sets SCC and
// holds the result beat.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sua_final (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_valid,
  output logic               s_ready,
  input  wire sua_pkg::s2_t  d,
  output logic               m_valid,
  input  wire logic          m_ready,
  output sua_pkg::out_t      q
);

  sua_pkg::out_t n;
  logic [6:0]    sum;
  logic [2:0]    lo_byte;
  logic [2:0]    hi_byte;
  logic          found;
  logic [5:0]    lo_pos;
  logic [5:0]    hi_pos;

  always_comb begin
    sum     = '0;
    lo_byte = '0;
    hi_byte = '0;
    for (int i = 0; i < 8; i++) sum = sum + {3'b000, d.cnt[i]};
    for (int i = 7; i >= 0; i--) if (d.any[i]) lo_byte = 3'(i);
    for (int i = 0; i < 8; i++) if (d.any[i]) hi_byte = 3'(i);
  end

  assign found  = |d.any;
  assign lo_pos = {lo_byte, d.lo[lo_byte]};
  assign hi_pos = {hi_byte, d.hi[hi_byte]};

  always_comb begin
    n.exec_v     = d.exec_v;
    n.pc         = d.pc;
    n.pc_changed = d.ctl.pc_changed;
    unique case (d.ctl.kind)
      sua_pkg::KIND_SIMPLE: n.dst = d.dst;
      sua_pkg::KIND_POPCNT: n.dst = {57'd0, sum};
      sua_pkg::KIND_LOWEST: n.dst = found ? {58'd0, lo_pos} : sua_pkg::NOT_FOUND;
      // Distance from bit 63 is the one's complement of the bit position.
      sua_pkg::KIND_LEAD:   n.dst = found ? {58'd0, ~hi_pos} : sua_pkg::NOT_FOUND;
      default:              n.dst = d.dst;
    endcase
    if (d.ctl.scc_dst) begin
      n.scc = |n.dst;
    end else if (d.ctl.scc_exec) begin
      n.scc = |d.exec_v;
    end else begin
      n.scc = d.ctl.scc;
    end
  end

  assign s_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s_ready) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q <= n;
    end
  end

  `ASSERT_CLKD(a_fin_hold, clk, rst, m_valid && !m_ready |=> m_valid && $stable(q), "result stage lost a stalled beat")

endmodule

`default_nettype wire

// ===== test/scalar_unary_alu_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scalar unary ALU testbench
// Drives single-source scalar instructions into the ALU through its valid and
// ready handshake, predicts each result beat with an independent software
// model of the instruction set or a typed-in answer, and checks them in order.
// ---------------------------------------------------------------------------

module scalar_unary_alu_tb;

  // Codes past the last real opcode. The block must pass state through for these.
  localparam logic [5:0]  OP_UNUSED_FIRST = 6'd46;
  localparam logic [5:0]  OP_UNUSED_LAST  = 6'd63;

  // Searches that find nothing report this value, zero-extended.
  localparam logic [63:0] NO_BIT     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] PC_ADVANCE = 64'd4;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  // Pipeline depth from the block header. Used only for the final drain.
  localparam int unsigned PIPE_DEPTH   = 3;
  localparam int unsigned DRAIN_CYCLES = 4 * PIPE_DEPTH + 10;

  localparam int unsigned DIRECTED_COUNT = 26;
  localparam int unsigned RANDOM_ITEMS   = 1824;

  // The slowest legal run is far below this. A hang is the only way to reach it.
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Long receiver hold-offs. The sender keeps offering beats while the ALU fills.
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned HOLD_COUNT     = 2;
  localparam int unsigned HOLD_FIRST_AT  = 200;
  localparam int unsigned HOLD_SPACING   = 900;

  // Filler values for the directed rows.
  localparam logic [63:0] D0 = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] E0 = 64'hF0F0_0000_FFFF_1234;
  localparam logic [63:0] P0 = 64'h0000_7FFF_0000_1000;

  typedef struct packed {
    logic [5:0]  action;
    logic [63:0] src;
    logic [63:0] dst_old;
    logic [63:0] exec_v;
    logic        scc;
    logic [63:0] pc;
  } alu_instr_t;

  typedef struct packed {
    logic [63:0] dst;
    logic [63:0] exec_v;
    logic        scc;
    logic        pc_changed;
    logic [63:0] pc;
  } alu_result_t;

  // One directed stimulus row. When given is set, want holds the typed-in
  // answer. Otherwise the predictor supplies it.
  typedef struct packed {
    alu_instr_t  ins;
    logic        given;
    alu_result_t want;
  } alu_row_t;

  localparam alu_result_t NO_RES = '0;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [5:0]  action    = '0;
  logic [63:0] src       = '0;
  logic [63:0] dst_old   = '0;
  logic [63:0] exec_in   = '0;
  logic        scc_in    = 1'b0;
  logic [63:0] pc_in     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] dst_new;
  logic [63:0] exec_out;
  logic        scc_out;
  logic        pc_changed;
  logic [63:0] pc_out;

  // Expected result beats, oldest first. A beat's result is pushed when its
  // instruction is accepted.
  alu_result_t pending_results[$];
  int unsigned mismatches     = 0;
  int unsigned items_accepted = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_burst     = 0;

  scalar_unary_alu dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .src        (src),
    .dst_old    (dst_old),
    .exec_in    (exec_in),
    .scc_in     (scc_in),
    .pc_in      (pc_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dst_new    (dst_new),
    .exec_out   (exec_out),
    .scc_out    (scc_out),
    .pc_changed (pc_changed),
    .pc_out     (pc_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Instruction-set predictor
  // -------------------------------------------------------------------------

  function automatic logic [63:0] ones_in(input logic [63:0] v);
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + 64'(v[i]);
    return n;
  endfunction

  function automatic logic [63:0] reversed(input logic [63:0] v, input int w);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < w; i++) if (v[i]) r[w - 1 - i] = 1'b1;
    return r;
  endfunction

  // Index of the lowest set bit within the low w bits.
  function automatic logic [63:0] lowest_set(input logic [63:0] v, input int w);
    for (int i = 0; i < w; i++) if (v[i]) return 64'(i);
    return NO_BIT;
  endfunction

  // Distance of the highest set bit from the top of a w-bit field.
  function automatic logic [63:0] leading_gap(input logic [63:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) if (v[i]) return 64'(w - 1 - i);
    return NO_BIT;
  endfunction

  // Quad mask (one bit per nonzero nibble) or whole-quad mask (the nibble filled).
  function automatic logic [63:0] nibble_summary(input logic [63:0] v, input int nibbles,
                                                 input logic whole);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < nibbles; i++) begin
      if (v[4 * i +: 4] != 4'h0) begin
        if (whole) r[4 * i +: 4] = 4'hF;
        else r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic alu_result_t execute_sop1(input alu_instr_t ins);
    alu_result_t r;
    logic [31:0] lo32;
    logic [63:0] s32;
    logic [63:0] new_exec;
    logic [63:0] rep;
    logic        saveexec;
    logic        wrexec;
    logic        scc_from_dst;
    lo32 = ins.src[31:0];
    s32 = {32'h0, lo32};
    r.dst = ins.dst_old;
    r.scc = ins.scc;
    r.pc_changed = 1'b0;
    r.pc = ins.pc;
    new_exec = ins.exec_v;
    saveexec = 1'b0;
    wrexec = 1'b0;
    scc_from_dst = 1'b0;
    rep = '0;
    case (ins.action)
      sua_pkg::OP_SETPC_B64: begin
        r.pc_changed = 1'b1;
        r.pc = ins.src;
      end
      sua_pkg::OP_GETPC_B64: r.dst = ins.pc + PC_ADVANCE;
      sua_pkg::OP_ABS_I32: begin
        r.dst = lo32[31] ? {32'h0, 32'h0 - lo32} : s32;
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_AND_SAVEEXEC: begin
        new_exec = ins.src & ins.exec_v;
        saveexec = 1'b1;
      end
      sua_pkg::OP_ANDN1_SAVEEXEC: begin
        new_exec = ~ins.src & ins.exec_v;
        saveexec = 1'b1;
      end
      sua_pkg::OP_ANDN1_WREXEC: begin
        new_exec = ~ins.src & ins.exec_v;
        wrexec = 1'b1;
      end
      sua_pkg::OP_ANDN2_SAVEEXEC: begin
        new_exec = ins.src & ~ins.exec_v;
        saveexec = 1'b1;
      end
      sua_pkg::OP_ANDN2_WREXEC: begin
        new_exec = ins.src & ~ins.exec_v;
        wrexec = 1'b1;
      end
      sua_pkg::OP_BCNT0_B32: begin
        r.dst = ones_in({32'h0, ~lo32});
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_BCNT0_B64: begin
        r.dst = ones_in(~ins.src);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_BCNT1_B32: begin
        r.dst = ones_in(s32);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_BCNT1_B64: begin
        r.dst = ones_in(ins.src);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_BITREPLICATE: begin
        for (int i = 0; i < 32; i++) rep[2 * i +: 2] = {2{lo32[i]}};
        r.dst = rep;
      end
      sua_pkg::OP_BITSET0_B32:
        r.dst = {32'h0, ins.dst_old[31:0] & ~(32'h1 << ins.src[4:0])};
      sua_pkg::OP_BITSET0_B64: r.dst = ins.dst_old & ~(64'h1 << ins.src[5:0]);
      sua_pkg::OP_BITSET1_B32:
        r.dst = {32'h0, ins.dst_old[31:0] | (32'h1 << ins.src[4:0])};
      sua_pkg::OP_BITSET1_B64: r.dst = ins.dst_old | (64'h1 << ins.src[5:0]);
      sua_pkg::OP_BREV_B32:    r.dst = reversed(s32, 32);
      sua_pkg::OP_BREV_B64:    r.dst = reversed(ins.src, 64);
      sua_pkg::OP_CMOV_B32:    if (ins.scc) r.dst = s32;
      sua_pkg::OP_CMOV_B64:    if (ins.scc) r.dst = ins.src;
      sua_pkg::OP_FF0_B32:     r.dst = lowest_set({32'h0, ~lo32}, 32);
      sua_pkg::OP_FF0_B64:     r.dst = lowest_set(~ins.src, 64);
      sua_pkg::OP_FF1_B32:     r.dst = lowest_set(s32, 32);
      sua_pkg::OP_FF1_B64:     r.dst = lowest_set(ins.src, 64);
      sua_pkg::OP_FLBIT_B32:   r.dst = leading_gap(s32, 32);
      sua_pkg::OP_FLBIT_B64:   r.dst = leading_gap(ins.src, 64);
      sua_pkg::OP_FLBIT_I32:
        r.dst = leading_gap(lo32[31] ? {32'h0, ~lo32} : s32, 32);
      sua_pkg::OP_FLBIT_I64:
        r.dst = leading_gap(ins.src[63] ? ~ins.src : ins.src, 64);
      sua_pkg::OP_MOV_B32:     r.dst = s32;
      sua_pkg::OP_MOV_B64:     r.dst = ins.src;
      sua_pkg::OP_NAND_SAVEEXEC: begin
        new_exec = ~(ins.src & ins.exec_v);
        saveexec = 1'b1;
      end
      sua_pkg::OP_NOR_SAVEEXEC: begin
        new_exec = ~(ins.src | ins.exec_v);
        saveexec = 1'b1;
      end
      sua_pkg::OP_NOT_B32: begin
        r.dst = {32'h0, ~lo32};
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_NOT_B64: begin
        r.dst = ~ins.src;
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_OR_SAVEEXEC: begin
        new_exec = ins.src | ins.exec_v;
        saveexec = 1'b1;
      end
      sua_pkg::OP_ORN2_SAVEEXEC: begin
        new_exec = ins.src | ~ins.exec_v;
        saveexec = 1'b1;
      end
      sua_pkg::OP_QUADMASK_B32: begin
        r.dst = nibble_summary(s32, 8, 1'b0);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_QUADMASK_B64: begin
        r.dst = nibble_summary(ins.src, 16, 1'b0);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_SEXT_I8:  r.dst = {32'h0, {24{ins.src[7]}}, ins.src[7:0]};
      sua_pkg::OP_SEXT_I16: r.dst = {32'h0, {16{ins.src[15]}}, ins.src[15:0]};
      sua_pkg::OP_SWAPPC_B64: begin
        r.dst = ins.pc + PC_ADVANCE;
        r.pc_changed = 1'b1;
        r.pc = ins.src;
      end
      sua_pkg::OP_WQM_B32: begin
        r.dst = nibble_summary(s32, 8, 1'b1);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_WQM_B64: begin
        r.dst = nibble_summary(ins.src, 16, 1'b1);
        scc_from_dst = 1'b1;
      end
      sua_pkg::OP_XNOR_SAVEEXEC: begin
        new_exec = ~(ins.src ^ ins.exec_v);
        saveexec = 1'b1;
      end
      sua_pkg::OP_XOR_SAVEEXEC: begin
        new_exec = ins.src ^ ins.exec_v;
        saveexec = 1'b1;
      end
      default: ;
    endcase
    r.exec_v = new_exec;
    // Saveexec forms return the old EXEC. Wrexec forms return the new one.
    if (saveexec) begin
      r.dst = ins.exec_v;
      r.scc = |new_exec;
    end else if (wrexec) begin
      r.dst = new_exec;
      r.scc = |new_exec;
    end
    if (scc_from_dst) r.scc = |r.dst;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // Operand mix: plain random words plus the shapes that stress the bit
  // searches, nibble masks, sign handling and bit-index operations.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = 64'h1 << $urandom_range(0, 63);
      3: v = ~(64'h1 << $urandom_range(0, 63));
      4: for (int i = 0; i < 16; i++) if ($urandom_range(0, 2) != 0) v[4 * i +: 4] = 4'h0;
      5: v = {32'h0, v[31:0]};
      6: v = {v[63:32], 32'h8000_0000};
      7: v = 64'($urandom_range(0, 127));
      8: v[63:8] = {56{v[7]}};
      default: ;
    endcase
    return v;
  endfunction

  // The first random beats walk every opcode once in order; after that the
  // opcode is drawn freely, with a small share of unused codes.
  function automatic alu_instr_t random_instr(input int unsigned n);
    alu_instr_t ins;
    if (n <= int'(sua_pkg::OP_XOR_SAVEEXEC)) ins.action = 6'(n);
    else if ($urandom_range(0, 99) < 6)
      ins.action = 6'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    else
      ins.action = 6'($urandom_range(sua_pkg::OP_SETPC_B64, sua_pkg::OP_XOR_SAVEEXEC));
    ins.src     = pick_operand();
    ins.dst_old = pick_operand();
    ins.exec_v  = pick_operand();
    ins.scc     = 1'($urandom_range(0, 1));
    ins.pc      = pick_operand();
    return ins;
  endfunction

  // Idle length shared by both sides: mostly zero or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offers one instruction beat, after an optional idle gap, and holds it until
  // the ALU takes it. Called at a rising edge and returns at the accepting edge,
  // so the next call can drive the following beat in the same step. Handshake
  // signals are sampled at the falling edge, where they have settled for the
  // coming rising edge.
  task automatic issue_instr(input alu_instr_t ins, input alu_result_t want);
    int unsigned idle;
    if (send_burst > 0) begin
      send_burst--;
      idle = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 60);
      idle = idle_length();
    end
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= ins.action;
    src      <= ins.src;
    dst_old  <= ins.dst_old;
    exec_in  <= ins.exec_v;
    scc_in   <= ins.scc;
    pc_in    <= ins.pc;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_results.push_back(want);
    items_accepted++;
    @(posedge clk);
  endtask

  // Directed rows: extremes, not-found searches, the most negative abs, PC
  // wrap, SCC-clear conditional move, 32-bit zero extension, unused codes and
  // the EXEC logic. Answers are typed in only where they are obvious.
  alu_row_t directed_rows [DIRECTED_COUNT] = '{
    '{'{sua_pkg::OP_SETPC_B64, 64'hFFFF_FFFF_FFFF_FFFC, D0, E0, 1'b1, P0}, 1'b1,
      '{D0, E0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFC}},
    '{'{sua_pkg::OP_GETPC_B64, 64'h0, D0, E0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b1,
      '{64'h2, E0, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE}},
    '{'{sua_pkg::OP_ABS_I32, 64'hFFFF_FFFF_8000_0000, D0, E0, 1'b0, P0}, 1'b1,
      '{64'h8000_0000, E0, 1'b1, 1'b0, P0}},
    '{'{sua_pkg::OP_ABS_I32, 64'h0000_0000_FFFF_FFFF, D0, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_ABS_I32, 64'h0, D0, E0, 1'b1, P0}, 1'b1,
      '{64'h0, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_FF1_B32, 64'hFFFF_FFFF_0000_0000, D0, E0, 1'b1, P0}, 1'b1,
      '{NO_BIT, E0, 1'b1, 1'b0, P0}},
    '{'{sua_pkg::OP_FF0_B64, ALL_ONES, D0, E0, 1'b0, P0}, 1'b1,
      '{NO_BIT, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_FLBIT_B64, 64'h0, D0, E0, 1'b0, P0}, 1'b1,
      '{NO_BIT, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_FLBIT_I32, 64'h0000_0000_FFFF_FFFF, D0, E0, 1'b1, P0}, 1'b1,
      '{NO_BIT, E0, 1'b1, 1'b0, P0}},
    '{'{sua_pkg::OP_FLBIT_I64, ALL_ONES, D0, E0, 1'b0, P0}, 1'b1,
      '{NO_BIT, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_FLBIT_B32, 64'h1, D0, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_CMOV_B64, ALL_ONES, D0, E0, 1'b0, P0}, 1'b1,
      '{D0, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_CMOV_B32, 64'hDEAD_BEEF_1234_5678, D0, E0, 1'b1, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_BITSET1_B32, 64'h3F, ALL_ONES, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_BITSET0_B64, 64'd63, ALL_ONES, E0, 1'b1, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_BCNT1_B64, ALL_ONES, D0, E0, 1'b0, P0}, 1'b1,
      '{64'd64, E0, 1'b1, 1'b0, P0}},
    '{'{sua_pkg::OP_BCNT0_B32, ALL_ONES, D0, E0, 1'b1, P0}, 1'b1,
      '{64'h0, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_QUADMASK_B32, 64'hFFFF_FFFF_F000_0F01, D0, E0, 1'b0, P0}, 1'b0,
      NO_RES},
    '{'{sua_pkg::OP_WQM_B64, 64'h8000_0000_0000_0001, D0, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{OP_UNUSED_LAST, ALL_ONES, D0, E0, 1'b1, P0}, 1'b1, '{D0, E0, 1'b1, 1'b0, P0}},
    '{'{OP_UNUSED_FIRST, ALL_ONES, D0, E0, 1'b0, P0}, 1'b1, '{D0, E0, 1'b0, 1'b0, P0}},
    '{'{sua_pkg::OP_ORN2_SAVEEXEC, 64'h0, D0, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_ANDN1_WREXEC, E0, D0, E0, 1'b1, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_SWAPPC_B64, 64'h0, D0, E0, 1'b0, ALL_ONES}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_SEXT_I8, 64'hFFFF_FFFF_FFFF_FF80, D0, E0, 1'b0, P0}, 1'b0, NO_RES},
    '{'{sua_pkg::OP_NOR_SAVEEXEC, 64'h0, D0, 64'h0, 1'b0, P0}, 1'b0, NO_RES}
  };

  // Sender: reset, the directed table, then the random beats, then the drain
  // and the verdict.
  initial begin
    alu_instr_t ins;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      issue_instr(directed_rows[k].ins,
                  directed_rows[k].given ? directed_rows[k].want
                                         : execute_sop1(directed_rows[k].ins));
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      ins = random_instr(n);
      issue_instr(ins, execute_sop1(ins));
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then give the pipeline time to show
    // any stray extra beat.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("scalar_unary_alu regression: pass");
    end else begin
      $display("scalar_unary_alu regression: fail");
    end
    $finish;
  end

  // Receiver: runs of ready broken by stalls of random length. Twice in the
  // run it holds off for a long stretch so the pipeline fills and in_ready
  // drops while the sender keeps offering beats.
  initial begin
    int unsigned run;
    int unsigned stall;
    int unsigned holds_done;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 20);
      repeat (run) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      if (holds_done < HOLD_COUNT &&
          items_accepted >= HOLD_FIRST_AT + HOLD_SPACING * holds_done) begin
        stall = LONG_HOLD;
        holds_done++;
      end else begin
        stall = idle_length();
      end
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result beats are taken at the falling edge before the accepting rising
  // edge and compared, in order, with the oldest expected result.
  always @(negedge clk) begin
    alu_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual dst %h",
                 $time, dst_new);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("dst_new", want.dst, dst_new);
        report_field("exec_out", want.exec_v, exec_out);
        report_field("scc_out", 64'(want.scc), 64'(scc_out));
        report_field("pc_changed", 64'(want.pc_changed), 64'(pc_changed));
        report_field("pc_out", want.pc, pc_out);
      end
    end
  end

  // Watchdog. Only a stuck handshake gets here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("scalar_unary_alu regression: fail");
      $finish;
    end
  end

endmodule
